@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: label");

// Same, for the usual clk / rst names.
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk, rst, prop)

`endif

@@ rtl/rbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants of the ROM bank mapper with RAM window.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned BANK_W      = 8;
  localparam int unsigned BANKS_W     = 9;
  localparam int unsigned PHYS_W      = 22;
  localparam int unsigned OFFSET_W    = 14;
  localparam int unsigned QUEUE_DEPTH = 2;

  // action bit positions
  localparam int unsigned ACT_WRITE_BIT = 0;
  localparam int unsigned ACT_WORD_BIT  = 1;

  localparam logic [ADDR_W-1:0] ADDR_SLOT0 = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT1 = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT2 = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_HI0   = 16'hFFFF;
  localparam logic [ADDR_W-1:0] ADDR_HI1   = 16'h3FFF;
  localparam logic [ADDR_W-1:0] ADDR_HI2   = 16'h7FFF;

  localparam logic [BANK_W-1:0] BANK_MASK = 8'h7F;
  localparam int unsigned RAM_EN_BIT = 7;

  localparam logic [BANKS_W-1:0] ROM_BANKS_RESET = 9'd1;

  typedef enum logic [1:0] {
    TGT_ROM     = 2'd0,
    TGT_RAM     = 2'd1,
    TGT_DISCARD = 2'd2,
    TGT_OUTSIDE = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    LD_SLOT0 = 2'd0,
    LD_SLOT1 = 2'd1,
    LD_SLOT2 = 2'd2
  } ld_sel_t;

  // One classified access, as queued between front and back.
  typedef struct packed {
    logic              wr;
    logic              word;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              ld_en;
    ld_sel_t           ld_sel;
    logic [BANK_W-1:0] ld_val;
  } access_t;

endpackage

@@ rtl/rbm_front.sv @@
// ----------------------------------------------------------------------------
// rbm_front
// Accepts bus accesses, decodes the access kind and any bank register load.
// ----------------------------------------------------------------------------
module rbm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [rbm_pkg::ADDR_W-1:0] cpu_addr,
  input  logic [rbm_pkg::DATA_W-1:0] wdata,
  output logic                  fe_valid,
  input  logic                  fe_ready,
  output rbm_pkg::access_t      fe_entry
);
  import rbm_pkg::*;

  access_t cls;
  logic    wr;
  logic    word;
  logic    lo_hit;
  logic    hi_hit;

  assign wr     = action[ACT_WRITE_BIT];
  assign word   = action[ACT_WORD_BIT];
  assign lo_hit = (cpu_addr == ADDR_SLOT0) || (cpu_addr == ADDR_SLOT1) ||
                  (cpu_addr == ADDR_SLOT2);
  // high byte of a word lands on a register address
  assign hi_hit = word && ((cpu_addr == ADDR_HI0) || (cpu_addr == ADDR_HI1) ||
                  (cpu_addr == ADDR_HI2));

  always_comb begin
    cls        = '0;
    cls.wr     = wr;
    cls.word   = word;
    cls.addr   = cpu_addr;
    cls.data   = wdata;
    cls.ld_en  = wr && (lo_hit || hi_hit);
    cls.ld_sel = LD_SLOT0;
    cls.ld_val = wdata[7:0];
    if (lo_hit) begin
      cls.ld_sel = (cpu_addr == ADDR_SLOT1) ? LD_SLOT1 :
                   (cpu_addr == ADDR_SLOT2) ? LD_SLOT2 : LD_SLOT0;
    end else begin
      cls.ld_val = wdata[15:8];
      cls.ld_sel = (cpu_addr == ADDR_HI1) ? LD_SLOT1 :
                   (cpu_addr == ADDR_HI2) ? LD_SLOT2 : LD_SLOT0;
    end
  end

  assign in_ready = !fe_valid || fe_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (in_ready) begin
      fe_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fe_entry <= cls;
    end
  end

endmodule

@@ rtl/rbm_queue.sv @@
// ----------------------------------------------------------------------------
// rbm_queue
// Small FIFO of classified accesses between front and back.
// ----------------------------------------------------------------------------
module rbm_queue #(
  parameter int unsigned DEPTH = rbm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  rbm_pkg::access_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output rbm_pkg::access_t pop_data
);
  import rbm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  access_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/rbm_back.sv @@
// ----------------------------------------------------------------------------
// rbm_back
// Translates each byte of an access, holds the bank registers, and reduces
// the selected bank modulo the bank count one bit per cycle.
// ----------------------------------------------------------------------------
module rbm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rbm_pkg::BANKS_W-1:0] rom_banks,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  rbm_pkg::access_t            q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  target,
  output logic [rbm_pkg::PHYS_W-1:0]  phys_addr,
  output logic                        write_enable,
  output logic [7:0]                  write_byte,
  output logic [rbm_pkg::BANK_W-1:0]  slot0_bank,
  output logic                        last
);
  import rbm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state;
  access_t             cur;
  logic                second;
  logic [2:0]          cnt;
  logic [BANKS_W-1:0]  rem;
  logic [BANK_W-1:0]   dividend;
  logic [BANK_W-1:0]   slot0_reg;
  logic [BANK_W-1:0]   slot1_control;
  logic [BANK_W-1:0]   slot2_bank;

  logic [BANKS_W-1:0]  divisor;
  logic [BANKS_W:0]    trial;
  logic [ADDR_W-1:0]   next_addr;
  logic [ADDR_W-1:0]   byte_addr;
  logic                emit_ok;
  target_t             tgt;
  logic [PHYS_W-1:0]   phys;
  logic                we;

  function automatic logic in_slot1(input logic [ADDR_W-1:0] a);
    in_slot1 = (a[15:14] == 2'b01);
  endfunction

  function automatic logic [BANK_W-1:0] bank_reg(input logic [ADDR_W-1:0] a,
                                                 input logic [BANK_W-1:0] s1,
                                                 input logic [BANK_W-1:0] s2);
    bank_reg = in_slot1(a) ? (s1 & BANK_MASK) : s2;
  endfunction

  // a zero bank count behaves as one bank
  assign divisor   = (rom_banks == '0) ? BANKS_W'(1) : rom_banks;
  assign trial     = {rem, dividend[BANK_W-1]};
  assign next_addr = cur.addr + 1'b1;
  assign byte_addr = second ? next_addr : cur.addr;
  assign emit_ok   = !out_valid || out_ready;
  assign q_ready   = (state == S_IDLE);

  always_comb begin
    we   = 1'b0;
    phys = {rem[BANK_W-1:0], byte_addr[OFFSET_W-1:0]};
    if (in_slot1(byte_addr)) begin
      tgt = cur.wr ? TGT_DISCARD : TGT_ROM;
    end else if (byte_addr[15:13] == 3'b101 && slot1_control[RAM_EN_BIT]) begin
      // RAM window is 8 KB, so the offset maps straight through
      tgt  = TGT_RAM;
      phys = PHYS_W'(byte_addr[12:0]);
      we   = cur.wr;
    end else if (byte_addr[15:14] == 2'b10) begin
      tgt = cur.wr ? TGT_DISCARD : TGT_ROM;
    end else begin
      tgt  = TGT_OUTSIDE;
      phys = PHYS_W'(byte_addr);
      we   = cur.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      second        <= 1'b0;
      cnt           <= '0;
      rem           <= '0;
      slot0_reg     <= '0;
      slot1_control <= '0;
      slot2_bank    <= '0;
    end else begin
      // in S_EMIT the output register is refilled below instead
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_data;
            second   <= 1'b0;
            dividend <= bank_reg(q_data.addr, slot1_control, slot2_bank);
            rem      <= '0;
            cnt      <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, divisor}) begin
            rem <= BANKS_W'(trial - {1'b0, divisor});
          end else begin
            rem <= trial[BANKS_W-1:0];
          end
          dividend <= dividend << 1;
          cnt      <= cnt + 1'b1;
          if (cnt == 3'd7) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid    <= 1'b1;
            target       <= tgt;
            phys_addr    <= phys;
            write_enable <= we;
            write_byte   <= cur.wr ? (second ? cur.data[15:8] : cur.data[7:0]) : 8'h00;
            slot0_bank   <= slot0_reg;
            last         <= second || !cur.word;
            if (cur.word && !second) begin
              second   <= 1'b1;
              dividend <= bank_reg(next_addr, slot1_control, slot2_bank);
              rem      <= '0;
              cnt      <= '0;
              state    <= S_DIV;
            end else begin
              // register loads land after every byte is translated
              if (cur.ld_en) begin
                unique case (cur.ld_sel)
                  LD_SLOT1: slot1_control <= cur.ld_val;
                  LD_SLOT2: slot2_bank    <= cur.ld_val;
                  default:  slot0_reg     <= cur.ld_val;
                endcase
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/rom_bank_mapper_with_ram_window_top.sv @@
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_ram_window_top
// Bank mapper: translates CPU bus accesses into ROM, RAM, discard or outside bytes.
// ----------------------------------------------------------------------------
// Each accepted access yields one byte result (byte access) or two (word
// access, low byte first, last set on the final one). Every byte runs through
// the back end in order: it takes the access from the queue (or, for the
// second byte of a word, starts it on loading the first), runs the
// bit-serial remainder that reduces the bank register by the configured bank
// count, and loads the output register. The front stage and a two-entry
// queue keep taking accesses while the back end works. rom_banks is written
// on the cfg channel, and the user must do so only while no access is in
// flight; the block does not enforce it.
module rom_bank_mapper_with_ram_window_top #(
  parameter int unsigned QUEUE_DEPTH = rbm_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [rbm_pkg::ADDR_W-1:0]  cpu_addr,
  input  logic [rbm_pkg::DATA_W-1:0]  wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  target,
  output logic [rbm_pkg::PHYS_W-1:0]  phys_addr,
  output logic                        write_enable,
  output logic [7:0]                  write_byte,
  output logic [rbm_pkg::BANK_W-1:0]  slot0_bank,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rbm_pkg::BANKS_W-1:0] cfg_data
);
  import rbm_pkg::*;

  logic               fe_valid;
  logic               fe_ready;
  access_t            fe_entry;
  logic               q_valid;
  logic               q_ready;
  access_t            q_data;
  logic [BANKS_W-1:0] rom_banks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_banks <= ROM_BANKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rom_banks <= cfg_data;
    end
  end

  rbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .cpu_addr (cpu_addr),
    .wdata    (wdata),
    .fe_valid (fe_valid),
    .fe_ready (fe_ready),
    .fe_entry (fe_entry)
  );

  rbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  rbm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rom_banks    (rom_banks),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .target       (target),
    .phys_addr    (phys_addr),
    .write_enable (write_enable),
    .write_byte   (write_byte),
    .slot0_bank   (slot0_bank),
    .last         (last)
  );

endmodule

@@ rtl/rbm_checker.sv @@
// ----------------------------------------------------------------------------
// rbm_checker
// Port-level checks on the bank mapper's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 target,
  input logic [rbm_pkg::PHYS_W-1:0] phys_addr,
  input logic                       write_enable,
  input logic [7:0]                 write_byte,
  input logic                       last
);
  import rbm_pkg::*;

  // stalled result holds
  `ASSERT_STD(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(phys_addr) && $stable(target) && $stable(last) && $stable(write_byte)))

  // ROM and discarded accesses never take a write strobe
  `ASSERT_STD(a_rom_no_we, (out_valid && (target == TGT_ROM || target == TGT_DISCARD)) |-> !write_enable)

  // a ROM read carries no write byte
  `ASSERT_STD(a_rom_read_byte, (out_valid && target == TGT_ROM) |-> (write_byte == 8'h00))

  // RAM offsets stay inside the 8 KB window
  `ASSERT_STD(a_ram_range, (out_valid && target == TGT_RAM) |-> (phys_addr[PHYS_W-1:13] == '0))

  // outside accesses pass the 16-bit CPU address
  `ASSERT_STD(a_outside_range, (out_valid && target == TGT_OUTSIDE) |-> (phys_addr[PHYS_W-1:16] == '0))

endmodule

bind rom_bank_mapper_with_ram_window_top rbm_checker u_rbm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .target       (target),
  .phys_addr    (phys_addr),
  .write_enable (write_enable),
  .write_byte   (write_byte),
  .last         (last)
);
